// File: rtl/core/rth_pkg.sv
package rth_pkg;

  // Channel and result field widths
  localparam int CH_W    = 8;
  localparam int HUE_W   = 16;
  localparam int SAT_W   = 16;
  localparam int LIGHT_W = 9;

  // Default number of fraction bits in the hue and saturation quotients
  localparam int FRACTION_BITS_DEF = 16;

  // Hue divisor is 6*d with d up to 255: 1530 fits in 11 bits
  localparam int HDEN_W = 11;
  // Saturation divisor is s or 510-s, at most 255 wherever it is used
  localparam int SDEN_W = 8;

endpackage

// File: rtl/core/rgb_to_hsl_converter.sv
// RGB to HSL converter. Accepts one 8-bit RGB pixel per clock whenever busy is
// low (busy is high only while rst is high) and returns hue, saturation and the
// lightness sum mx+mn, marked by a one-cycle done strobe. The two restoring
// dividers, hue and saturation side by side, produce one quotient bit per
// pipeline stage. The results are not held: the receiver must take each word
// in the cycle done is high.
module rgb_to_hsl_converter #(
  parameter int FRACTION_BITS = rth_pkg::FRACTION_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [rth_pkg::CH_W-1:0]    red,
  input  logic [rth_pkg::CH_W-1:0]    green,
  input  logic [rth_pkg::CH_W-1:0]    blue,
  output logic                        done,
  output logic [rth_pkg::HUE_W-1:0]   hue,
  output logic [rth_pkg::SAT_W-1:0]   saturation,
  output logic [rth_pkg::LIGHT_W-1:0] lightness_sum
);
  import rth_pkg::*;

  localparam int LAT = FRACTION_BITS + 3;
  localparam logic [FRACTION_BITS-1:0] FULL = {FRACTION_BITS{1'b1}};

  typedef enum logic [1:0] {SEL_RED, SEL_GREEN, SEL_BLUE} max_sel_t;

  logic accept;

  assign busy   = rst;
  assign accept = start && !busy;

  // ---------------------------------------------------------------- stage A
  logic               a_valid;
  logic [CH_W-1:0]    a_r, a_g, a_b, a_mx, a_mn;
  max_sel_t           a_sel;
  logic [CH_W-1:0]    mx_next, mn_next;
  max_sel_t           sel_next;

  always_comb begin
    // red wins ties, then green
    if (red >= green && red >= blue) begin
      sel_next = SEL_RED;
      mx_next  = red;
    end else if (green >= blue) begin
      sel_next = SEL_GREEN;
      mx_next  = green;
    end else begin
      sel_next = SEL_BLUE;
      mx_next  = blue;
    end
    mn_next = red;
    if (green < mn_next) mn_next = green;
    if (blue < mn_next) mn_next = blue;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= accept;
    end
    a_r   <= red;
    a_g   <= green;
    a_b   <= blue;
    a_mx  <= mx_next;
    a_mn  <= mn_next;
    a_sel <= sel_next;
  end

  // ---------------------------------------------------------------- stage B
  // Index 0 of the divider arrays is stage B; index k holds k quotient bits.
  logic                     dv_valid [0:FRACTION_BITS];
  logic [HDEN_W-1:0]        hrem     [0:FRACTION_BITS];
  logic [HDEN_W-1:0]        hden     [0:FRACTION_BITS];
  logic [SDEN_W-1:0]        srem     [0:FRACTION_BITS];
  logic [SDEN_W-1:0]        sden     [0:FRACTION_BITS];
  logic [FRACTION_BITS-1:0] hq       [0:FRACTION_BITS];
  logic [FRACTION_BITS-1:0] sq       [0:FRACTION_BITS];
  logic [LIGHT_W-1:0]       lsum     [0:FRACTION_BITS];
  logic                     grey     [0:FRACTION_BITS];
  logic                     full     [0:FRACTION_BITS];

  logic [CH_W-1:0]    d;
  logic [LIGHT_W-1:0] s;
  logic [HDEN_W-1:0]  rx, gx, bx, dx, d6, n6;
  logic [SDEN_W-1:0]  sden_next;

  always_comb begin
    d  = a_mx - a_mn;
    s  = LIGHT_W'(a_mx) + LIGHT_W'(a_mn);
    rx = HDEN_W'(a_r);
    gx = HDEN_W'(a_g);
    bx = HDEN_W'(a_b);
    dx = HDEN_W'(d);
    d6 = (dx << 2) + (dx << 1);
    // n6 = H6 * d, below 6d whenever d is nonzero; intermediate wrap cancels out
    case (a_sel)
      SEL_RED:   n6 = (a_g >= a_b) ? gx - bx : d6 - (bx - gx);
      SEL_GREEN: n6 = (dx << 1) + bx - rx;
      SEL_BLUE:  n6 = (dx << 2) + rx - gx;
      default:   n6 = (dx << 2) + rx - gx;
    endcase
    if (s < LIGHT_W'(255)) begin
      sden_next = s[SDEN_W-1:0];
    end else begin
      sden_next = SDEN_W'(LIGHT_W'(510) - s);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_valid[0] <= 1'b0;
    end else begin
      dv_valid[0] <= a_valid;
    end
    hrem[0] <= n6;
    hden[0] <= d6;
    srem[0] <= d;
    sden[0] <= sden_next;
    hq[0]   <= '0;
    sq[0]   <= '0;
    lsum[0] <= s;
    grey[0] <= (d == '0);
    // ratio of exactly one clamps to all ones
    full[0] <= (d == sden_next);
  end

  // ------------------------------------------------------- divider stages
  for (genvar k = 1; k <= FRACTION_BITS; k++) begin : g_div
    logic [HDEN_W:0] h2;
    logic [SDEN_W:0] s2;
    logic            hge, sge;

    always_comb begin
      h2  = {hrem[k-1], 1'b0};
      s2  = {srem[k-1], 1'b0};
      hge = h2 >= {1'b0, hden[k-1]};
      sge = s2 >= {1'b0, sden[k-1]};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_valid[k] <= 1'b0;
      end else begin
        dv_valid[k] <= dv_valid[k-1];
      end
      hrem[k] <= hge ? HDEN_W'(h2 - {1'b0, hden[k-1]}) : h2[HDEN_W-1:0];
      srem[k] <= sge ? SDEN_W'(s2 - {1'b0, sden[k-1]}) : s2[SDEN_W-1:0];
      hq[k]   <= {hq[k-1][FRACTION_BITS-2:0], hge};
      sq[k]   <= {sq[k-1][FRACTION_BITS-2:0], sge};
      hden[k] <= hden[k-1];
      sden[k] <= sden[k-1];
      lsum[k] <= lsum[k-1];
      grey[k] <= grey[k-1];
      full[k] <= full[k-1];
    end
  end

  // ---------------------------------------------------------- output word
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dv_valid[FRACTION_BITS];
    end
    lightness_sum <= lsum[FRACTION_BITS];
    if (grey[FRACTION_BITS]) begin
      hue        <= '0;
      saturation <= '0;
    end else begin
      hue        <= HUE_W'(hq[FRACTION_BITS]);
      saturation <= full[FRACTION_BITS] ? SAT_W'(FULL) : SAT_W'(sq[FRACTION_BITS]);
    end
  end

  // ----------------------------------------------------------- assertions
  a_done_from_accept: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, LAT))
    else $error("result word without an accepted pixel");

  a_grey_zero: assert property (@(posedge clk) disable iff (rst)
    done && (lightness_sum == LIGHT_W'(0) || lightness_sum == LIGHT_W'(510))
      |-> hue == '0 && saturation == '0)
    else $error("black or white pixel with nonzero hue or saturation");

  a_sum_range: assert property (@(posedge clk) disable iff (rst)
    done |-> lightness_sum <= LIGHT_W'(510))
    else $error("lightness sum out of range");

endmodule

// File: tb/rgb_to_hsl_converter_tb.sv
module rgb_to_hsl_converter_tb;
  import rth_pkg::*;

  localparam int FRAC        = FRACTION_BITS_DEF;
  localparam int LATENCY     = FRAC + 3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [HUE_W-1:0]   hue;
    logic [SAT_W-1:0]   sat;
    logic [LIGHT_W-1:0] light;
  } hsl_word_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [CH_W-1:0]    red = '0;
  logic [CH_W-1:0]    green = '0;
  logic [CH_W-1:0]    blue = '0;
  logic               done;
  logic [HUE_W-1:0]   hue;
  logic [SAT_W-1:0]   saturation;
  logic [LIGHT_W-1:0] lightness_sum;

  hsl_word_t hsl_expected_q[$];
  int        mismatch_count = 0;
  int        pixels_sent = 0;
  int        results_checked = 0;
  int        grey_pixels = 0;
  int        tied_max_pixels = 0;
  int        cycle_count = 0;
  bit        sender_idles = 1'b1;

  rgb_to_hsl_converter #(
    .FRACTION_BITS(FRAC)
  ) uut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .done         (done),
    .hue          (hue),
    .saturation   (saturation),
    .lightness_sum(lightness_sum)
  );

  always #5 clk = ~clk;

  // Exact fixed-point HSL of one pixel; red wins max ties, then green.
  function automatic hsl_word_t hsl_predict(logic [CH_W-1:0] r, logic [CH_W-1:0] g,
                                            logic [CH_W-1:0] b);
    longint unsigned rr, gg, bb, mx, mn, d, s, n6, q, full;
    hsl_word_t w;
    rr = r;
    gg = g;
    bb = b;
    full = (64'd1 << FRAC) - 1;
    mx = rr;
    mn = rr;
    if (gg > mx) mx = gg;
    if (bb > mx) mx = bb;
    if (gg < mn) mn = gg;
    if (bb < mn) mn = bb;
    d = mx - mn;
    s = mx + mn;
    w = '0;
    w.light = LIGHT_W'(s);
    if (d != 0) begin
      if (mx == rr) n6 = (gg >= bb) ? gg - bb : 6 * d - (bb - gg);
      else if (mx == gg) n6 = 2 * d + bb - rr;
      else n6 = 4 * d + rr - gg;
      q = (n6 << FRAC) / (6 * d);
      if (q > full) q = full;
      w.hue = HUE_W'(q);
      // Below mid-lightness divide by s, else by the distance to white
      q = (s < 255) ? (d << FRAC) / s : (d << FRAC) / (510 - s);
      if (q > full) q = full;
      w.sat = SAT_W'(q);
    end
    return w;
  endfunction

  function automatic void report_mismatch(string what, hsl_word_t want, hsl_word_t got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("%0d: %s: expected hue %0d sat %0d light %0d, got hue %0d sat %0d light %0d",
               cycle_count, what, want.hue, want.sat, want.light, got.hue, got.sat,
               got.light);
  endfunction

  // Check each result word against the oldest pending pixel, then log accepted pixels.
  always @(posedge clk) begin : hsl_check
    hsl_word_t got;
    hsl_word_t want;
    if (!rst && done) begin
      got.hue = hue;
      got.sat = saturation;
      got.light = lightness_sum;
      if (hsl_expected_q.size() == 0) begin
        report_mismatch("result with nothing pending", '0, got);
      end else begin
        want = hsl_expected_q.pop_front();
        results_checked++;
        if (got.hue != want.hue || got.sat != want.sat || got.light != want.light)
          report_mismatch("wrong result", want, got);
      end
    end
    if (start && !busy) begin
      hsl_expected_q.push_back(hsl_predict(red, green, blue));
      if (red == green && green == blue) grey_pixels++;
      else if ((red == green && red >= blue) || (red == blue && red >= green) ||
               (green == blue && green >= red))
        tied_max_pixels++;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout with %0d results pending", hsl_expected_q.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Called just after a rising edge; returns just after the edge that took the word.
  task automatic send_pixel(input logic [CH_W-1:0] r, input logic [CH_W-1:0] g,
                            input logic [CH_W-1:0] b);
    red <= r;
    green <= g;
    blue <= b;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    pixels_sent++;
  endtask

  task automatic sender_gap();
    if (sender_idles && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (hsl_expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic make_pixel(output logic [CH_W-1:0] r, output logic [CH_W-1:0] g,
                            output logic [CH_W-1:0] b);
    int hi, lo, mid, total;
    logic [CH_W-1:0] c[3];
    hi = $urandom_range(0, 255);
    lo = $urandom_range(0, hi);
    mid = $urandom_range(lo, hi);
    case ($urandom_range(0, 9))
      5: begin
        lo = hi;
        mid = hi;
      end
      6: mid = hi;
      7: mid = lo;
      8: begin
        hi = 254 + $urandom_range(0, 1);
        lo = $urandom_range(0, 1);
        mid = ($urandom_range(0, 1) == 0) ? lo : hi;
      end
      9: begin
        // Land near the mid-lightness switch of the saturation divisor
        total = $urandom_range(253, 257);
        hi = $urandom_range((total + 1) / 2, (total > 255) ? 255 : total);
        lo = total - hi;
        mid = $urandom_range(lo, hi);
      end
      default: ;
    endcase
    c[0] = CH_W'(hi);
    c[1] = CH_W'(mid);
    c[2] = CH_W'(lo);
    case ($urandom_range(0, 5))
      0: begin r = c[0]; g = c[1]; b = c[2]; end
      1: begin r = c[0]; g = c[2]; b = c[1]; end
      2: begin r = c[1]; g = c[0]; b = c[2]; end
      3: begin r = c[1]; g = c[2]; b = c[0]; end
      4: begin r = c[2]; g = c[0]; b = c[1]; end
      default: begin r = c[2]; g = c[1]; b = c[0]; end
    endcase
  endtask

  task automatic test_directed();
    send_pixel(8'd0, 8'd0, 8'd0);       // black
    send_pixel(8'd255, 8'd255, 8'd255); // white
    send_pixel(8'd128, 8'd128, 8'd128); // mid grey
    send_pixel(8'd255, 8'd0, 8'd0);     // pure red, saturation hits full scale
    send_pixel(8'd0, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd255);
    send_pixel(8'd255, 8'd255, 8'd0);   // red and green tie
    send_pixel(8'd0, 8'd255, 8'd255);   // green and blue tie
    send_pixel(8'd255, 8'd0, 8'd255);   // red and blue tie
    send_pixel(8'd255, 8'd0, 8'd1);     // red max, hue wraps just below a full turn
    send_pixel(8'd1, 8'd0, 8'd0);       // dark, ratio of one
    send_pixel(8'd255, 8'd254, 8'd254); // bright, ratio of one
    send_pixel(8'd200, 8'd100, 8'd55);  // sum exactly 255
    send_pixel(8'd199, 8'd100, 8'd55);  // sum 254
    send_pixel(8'd201, 8'd100, 8'd55);  // sum 256
    send_pixel(8'd10, 8'd240, 8'd100);
    send_pixel(8'd30, 8'd60, 8'd250);
    send_pixel(8'd170, 8'd85, 8'd15);
    send_pixel(8'd85, 8'd170, 8'd255);
    send_pixel(8'd1, 8'd2, 8'd3);
  endtask

  task automatic test_random_idle(input int count);
    logic [CH_W-1:0] r, g, b;
    for (int i = 0; i < count; i++) begin
      // Alternate stretches with and without sender gaps
      sender_idles = ((i / 100) % 3) != 2;
      make_pixel(r, g, b);
      send_pixel(r, g, b);
      sender_gap();
    end
    sender_idles = 1'b1;
  endtask

  task automatic test_pressure();
    logic [CH_W-1:0] r, g, b;
    for (int burst = 0; burst < 4; burst++) begin
      repeat ($urandom_range(1, 30)) begin
        make_pixel(r, g, b);
        send_pixel(r, g, b);
      end
      wait_drained();
    end
  endtask

  task automatic test_back_to_back(input int count);
    logic [CH_W-1:0] r, g, b;
    sender_idles = 1'b0;
    repeat (count) begin
      make_pixel(r, g, b);
      send_pixel(r, g, b);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_idle(1200);
    test_pressure();
    test_random_idle(400);
    test_back_to_back(400);
    wait_drained();
    repeat (LATENCY + 4) @(posedge clk);
    $display("Sent %0d pixels (%0d grey, %0d with tied maxima), %0d results checked.",
             pixels_sent, grey_pixels, tied_max_pixels, results_checked);
    $display("Covered all channel extremes, every hue sextant and both saturation ranges.");
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
